// ===== sv/rle_pkg.sv =====
// Shared types and constants for the run-length icon bitmap decoder.
// Used by every module of the block; depends on nothing else.
package rle_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_icon;
  } in_word_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic        pixel_set;
    logic [3:0]  pixel_color;
    logic        off_screen;
    logic        last_of_byte;
    logic        icon_done;
  } out_word_t;

  // Command handed from the front end to the back end through the queue.
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_CODE  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] arg_a;   // icon columns for a begin, the code byte otherwise
    logic [7:0] arg_b;   // icon rows for a begin
  } cmd_t;

  // Configuration register indexes.
  localparam logic [7:0] REG_ORIGIN_X   = 8'd0;
  localparam logic [7:0] REG_ORIGIN_Y   = 8'd1;
  localparam logic [7:0] REG_DRAW_COLOR = 8'd2;
  localparam logic [7:0] REG_SCALE      = 8'd3;

  typedef struct packed {
    logic [9:0] origin_x;
    logic [9:0] origin_y;
    logic [3:0] draw_color;
    logic [2:0] scale;
  } cfg_t;

  // Code byte fields.
  localparam int RUN_FLAG_BIT  = 7;
  localparam int RUN_VALUE_BIT = 6;
  localparam int LITERAL_PIXELS = 7;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== sv/rle_icon_bitmap_decoder.sv =====
// Top level of the run-length icon bitmap decoder.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on rle_pkg, rle_front, rle_queue and rle_back.
//
// Usage: icon bytes enter on the input channel (in_valid / in_stall). A word
// with start_icon set carries the icon width; the next two words carry the
// height and a byte count, which is not used. Every later word is a code:
// a run (bit 7 set, length in bits 5..0, value in bit 6) or a literal of
// seven pixels, least significant bit first. Pixel words leave on the output
// channel (out_valid / out_stall), column by column, each column from top to
// bottom, at screen coordinates origin plus index times scale clamped to 1..4.
// Configuration is written on the cfg channel by register index; cfg_ready is
// always high, and writes are meant to happen while the block is idle.
// Timing: an input word is accepted while the two-entry command queue is not
// full; the back end pops a command whenever it is idle and, for a code, the
// pixel stepper state and then the registered output stage lie between the
// pop and the first pixel word. The back end then emits one pixel word per
// cycle while the receiver does not stall. The single pixel stepper in the
// back end sets this rate.
// A stalled receiver holds the registered output word and freezes the back
// end; the queue then fills and in_stall rises. Reset clears the queue, drops
// any icon in progress and restores the register reset values.
module rle_icon_bitmap_decoder import rle_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  // The register file accepts a write in every cycle.
  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= 10'd0;
      cfg.origin_y   <= 10'd0;
      cfg.draw_color <= 4'd1;
      cfg.scale      <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:   cfg.origin_x   <= cfg_data;
        REG_ORIGIN_Y:   cfg.origin_y   <= cfg_data;
        REG_DRAW_COLOR: cfg.draw_color <= cfg_data[3:0];
        REG_SCALE:      cfg.scale      <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: header tracking and byte classification.
  rle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Queue that lets the front end keep accepting while pixels are produced.
  rle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back end: pixel stepper and registered output stage.
  rle_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== sv/rle_front.sv =====
// Front end: accepts stream bytes, tracks the header phase and classifies
// each byte into a queue command. Depends on rle_pkg.
module rle_front import rle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_word_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_ROWS  = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] icon_cols;
  logic [7:0] icon_rows;
  logic       accept;

  assign accept = in_valid && !q_full;

  always_comb begin
    phase_next = phase;
    q_push     = 1'b0;
    q_cmd.kind  = CMD_CODE;
    q_cmd.arg_a = in_data.data_byte;
    q_cmd.arg_b = icon_rows;
    if (in_data.start_icon) begin
      phase_next = PH_ROWS;
    end else begin
      case (phase)
        PH_ROWS: begin
          phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          // The byte count is not used; this byte only opens the icon body.
          phase_next  = PH_CODE;
          q_push      = 1'b1;
          q_cmd.kind  = CMD_BEGIN;
          q_cmd.arg_a = icon_cols;
        end
        default: begin
          phase_next = PH_CODE;
          q_push     = 1'b1;
        end
      endcase
    end
    q_push = q_push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CODE;
      icon_cols <= '0;
      icon_rows <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (in_data.start_icon) begin
        icon_cols <= in_data.data_byte;
      end else if (phase == PH_ROWS) begin
        icon_rows <= in_data.data_byte;
      end
    end
  end

endmodule

// ===== sv/rle_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on rle_pkg for the command type and depth.
module rle_queue import rle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rle_back.sv =====
// Back end: walks the icon column by column and emits one pixel word per
// cycle unless the output stalls, into a registered output stage. Depends on rle_pkg.
module rle_back import rle_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_not_empty,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [10:0] X_LIMIT = 11'(SCREEN_WIDTH);
  localparam logic [10:0] Y_LIMIT = 11'(SCREEN_HEIGHT);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PIXEL = 1'b1;

  logic       state;
  logic [7:0] icon_cols;
  logic [7:0] icon_rows;
  logic [7:0] col_index;
  logic [7:0] row_index;
  logic       finished;
  logic       is_run;
  logic       run_value;
  logic [6:0] literal_bits;
  logic [5:0] cnt_last;
  logic [5:0] k;

  logic [2:0]  s_eff;
  logic [8:0]  row_inc;
  logic [8:0]  col_inc;
  logic        row_wrap;
  logic        icon_end;
  logic        pix_last;
  logic        pix_v;
  logic        advance;
  logic [10:0] px;
  logic [10:0] py;
  logic [5:0]  code_cnt;

  always_comb begin
    if (cfg.scale == 3'd0) begin
      s_eff = 3'd1;
    end else if (cfg.scale > 3'd4) begin
      s_eff = 3'd4;
    end else begin
      s_eff = cfg.scale;
    end
  end

  assign q_pop   = (state == ST_IDLE) && q_not_empty;
  assign advance = (state == ST_PIXEL) && (!out_valid || !out_stall);

  assign row_inc  = {1'b0, row_index} + 9'd1;
  assign col_inc  = {1'b0, col_index} + 9'd1;
  assign row_wrap = (row_inc >= {1'b0, icon_rows});
  assign icon_end = row_wrap && (col_inc >= {1'b0, icon_cols});
  assign pix_last = (k == cnt_last) || icon_end;
  assign pix_v    = is_run ? run_value : literal_bits[k[2:0]];

  // The index times scale product needs up to ten bits, so it is formed at
  // the full coordinate width.
  assign px = 11'(cfg.origin_x) + 11'(col_index) * 11'(s_eff);
  assign py = 11'(cfg.origin_y) + 11'(row_index) * 11'(s_eff);

  assign code_cnt = q_head.arg_a[RUN_FLAG_BIT] ? q_head.arg_a[5:0] : 6'(LITERAL_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finished  <= 1'b1;
      icon_cols <= '0;
      icon_rows <= '0;
      col_index <= '0;
      row_index <= '0;
    end else if (q_pop) begin
      if (q_head.kind == CMD_BEGIN) begin
        icon_cols <= q_head.arg_a;
        icon_rows <= q_head.arg_b;
        col_index <= '0;
        row_index <= '0;
        finished  <= (q_head.arg_a == 8'd0) || (q_head.arg_b == 8'd0);
      end else if (!finished && (code_cnt != 6'd0)) begin
        state <= ST_PIXEL;
      end
    end else if (advance) begin
      if (row_wrap) begin
        row_index <= '0;
        col_index <= col_inc[7:0];
      end else begin
        row_index <= row_inc[7:0];
      end
      if (icon_end) begin
        finished <= 1'b1;
      end
      if (pix_last) begin
        state <= ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      is_run       <= q_head.arg_a[RUN_FLAG_BIT];
      run_value    <= q_head.arg_a[RUN_VALUE_BIT];
      literal_bits <= q_head.arg_a[6:0];
      cnt_last     <= code_cnt - 6'd1;
      k            <= '0;
    end else if (advance) begin
      k <= k + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.pixel_x      <= px;
      out_data.pixel_y      <= py;
      out_data.pixel_set    <= pix_v;
      out_data.pixel_color  <= pix_v ? cfg.draw_color : 4'd0;
      out_data.off_screen   <= (px >= X_LIMIT) || (py >= Y_LIMIT);
      out_data.last_of_byte <= pix_last;
      out_data.icon_done    <= icon_end;
    end
  end

endmodule
